>>> rtl/core/cpid_pkg.sv
// shared types, register codes and clamp functions for the clamped pid controller
// depends on nothing; imported by both rtl modules, the checker and the testbench
`timescale 1ns / 1ps
`default_nettype none

package cpid_pkg;

    localparam int VALUE_W    = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_INTEG_GAIN    = 3'd1,
        REG_DERIV_GAIN    = 3'd2,
        REG_INTEGRAL_LOW  = 3'd3,
        REG_INTEGRAL_HIGH = 3'd4,
        REG_DRIVE_LOW     = 3'd5,
        REG_DRIVE_HIGH    = 3'd6
    } t_cfg_index;

    // current register settings, handed from the register file to the datapath
    typedef struct packed {
        logic signed [VALUE_W-1:0] prop_gain;
        logic signed [VALUE_W-1:0] integ_gain;
        logic signed [VALUE_W-1:0] deriv_gain;
        logic signed [VALUE_W-1:0] integral_low;
        logic signed [VALUE_W-1:0] integral_high;
        logic signed [VALUE_W-1:0] drive_low;
        logic signed [VALUE_W-1:0] drive_high;
    } t_cpid_cfg;

    localparam t_cpid_cfg CFG_RESET = '{
        prop_gain:     16'sd16,
        integ_gain:    16'sd8,
        deriv_gain:    16'sd1,
        integral_low:  -16'sd512,
        integral_high: 16'sd512,
        drive_low:     16'sd0,
        drive_high:    16'sd4095
    };

    // clamp a 17-bit value, lower bound first so that the upper bound wins when inverted
    function automatic logic signed [VALUE_W-1:0] clamp17(
        input logic signed [VALUE_W:0]   value,
        input logic signed [VALUE_W-1:0] lo,
        input logic signed [VALUE_W-1:0] hi
    );
        logic signed [VALUE_W:0] t;
        logic signed [VALUE_W:0] lo_x;
        logic signed [VALUE_W:0] hi_x;
        lo_x = lo;
        hi_x = hi;
        t = value;
        if (t < lo_x) begin
            t = lo_x;
        end
        if (t > hi_x) begin
            t = hi_x;
        end
        return t[VALUE_W-1:0];
    endfunction

    // clamp the 34-bit weighted sum in the same order
    function automatic logic signed [VALUE_W-1:0] clamp34(
        input logic signed [2*VALUE_W+1:0] value,
        input logic signed [VALUE_W-1:0]   lo,
        input logic signed [VALUE_W-1:0]   hi
    );
        logic signed [2*VALUE_W+1:0] t;
        logic signed [2*VALUE_W+1:0] lo_x;
        logic signed [2*VALUE_W+1:0] hi_x;
        lo_x = lo;
        hi_x = hi;
        t = value;
        if (t < lo_x) begin
            t = lo_x;
        end
        if (t > hi_x) begin
            t = hi_x;
        end
        return t[VALUE_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/cpid_regs.sv
// configuration register file of the clamped pid controller: gains and limits
// depends on cpid_pkg
`timescale 1ns / 1ps
`default_nettype none

module cpid_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [cpid_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [cpid_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output cpid_pkg::t_cpid_cfg                   o_cfg
);
    import cpid_pkg::*;

    t_cpid_cfg r_cfg;
    t_cpid_cfg n_cfg;

    // decode the write, unknown indexes leave everything alone
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PROP_GAIN:     n_cfg.prop_gain     = i_cfg_data;
                REG_INTEG_GAIN:    n_cfg.integ_gain    = i_cfg_data;
                REG_DERIV_GAIN:    n_cfg.deriv_gain    = i_cfg_data;
                REG_INTEGRAL_LOW:  n_cfg.integral_low  = i_cfg_data;
                REG_INTEGRAL_HIGH: n_cfg.integral_high = i_cfg_data;
                REG_DRIVE_LOW:     n_cfg.drive_low     = i_cfg_data;
                REG_DRIVE_HIGH:    n_cfg.drive_high    = i_cfg_data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> rtl/core/clamped_pid_controller.sv
// Clamped PID controller. Each request on the slave stream carries a measured value and a
// setpoint; one drive value leaves on the master stream for each. A new request can be taken
// every cycle unless all stages are full and the master stream stalls. The pipeline runs
// through an input register, an error stage that also updates the stored previous error and
// the clamped integral, a stage of three 16 x 16 multipliers, and the sum-and-clamp output
// register. Each stage holds its own valid bit, so requests keep flowing into empty stages
// while a finished result waits downstream. The user must write gains and limits through the
// plain write port only while no request is in flight, which the block does not enforce.
// writes to unknown indexes are ignored; depends on cpid_pkg and cpid_regs
`timescale 1ns / 1ps
`default_nettype none

module clamped_pid_controller #(
    parameter logic signed [15:0] ERROR_MIN = -16'sd256,
    parameter logic signed [15:0] ERROR_MAX = 16'sd256,
    parameter logic signed [15:0] DIFF_MIN  = -16'sd256,
    parameter logic signed [15:0] DIFF_MAX  = 16'sd256
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // configuration write port
    input  wire logic                                 i_cfg_we,
    input  wire logic [cpid_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [cpid_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // slave stream
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [2*cpid_pkg::VALUE_W-1:0]       s_axis_tdata,  // measured, setpoint
    // master stream
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [cpid_pkg::VALUE_W-1:0]              m_axis_tdata   // drive
);
    import cpid_pkg::*;

    localparam int PROD_W = 2 * VALUE_W;
    localparam int SUM_W  = PROD_W + 2;

    t_cpid_cfg w_cfg;

    // stage valids and per-stage ready
    logic r_v0, r_v1, r_v2, r_v3;
    logic w_rdy0, w_rdy1, w_rdy2, w_rdy3;
    logic w_ld1;

    // stage payloads and state
    logic signed [VALUE_W-1:0] r_meas, r_setp;
    logic signed [VALUE_W-1:0] r_err, r_diff, r_integ_val;
    logic signed [VALUE_W-1:0] r_prev_err, r_integ;
    logic signed [PROD_W-1:0]  r_p_prod, r_i_prod, r_d_prod;
    logic signed [VALUE_W-1:0] r_drive;

    logic signed [VALUE_W:0]   w_err_raw, w_diff_raw, w_integ_raw;
    logic signed [VALUE_W-1:0] w_err, w_diff, w_integ;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [VALUE_W-1:0] w_drive;

    cpid_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // flow control: a stage moves when it is empty or the next one moves
    assign w_rdy3 = !r_v3 || m_axis_tready;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign w_rdy0 = !r_v0 || w_rdy1;
    assign w_ld1  = r_v0 && w_rdy1;

    assign s_axis_tready = w_rdy0;
    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = r_drive;

    // error, difference and anti-windup integral
    always_comb begin
        w_err_raw   = 17'(r_setp) - 17'(r_meas);
        w_err       = clamp17(w_err_raw, ERROR_MIN, ERROR_MAX);
        w_diff_raw  = 17'(w_err) - 17'(r_prev_err);
        w_diff      = clamp17(w_diff_raw, DIFF_MIN, DIFF_MAX);
        w_integ_raw = 17'(r_integ) + 17'(w_err);
        w_integ     = clamp17(w_integ_raw, w_cfg.integral_low, w_cfg.integral_high);
    end

    // weighted sum and drive clamp
    always_comb begin
        w_sum   = SUM_W'(r_p_prod) + SUM_W'(r_i_prod) + SUM_W'(r_d_prod);
        w_drive = clamp34(w_sum, w_cfg.drive_low, w_cfg.drive_high);
    end

    // valid bits and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0       <= 1'b0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_prev_err <= '0;
            r_integ    <= '0;
        end else begin
            if (w_rdy0) begin
                r_v0 <= s_axis_tvalid;
            end
            if (w_rdy1) begin
                r_v1 <= r_v0;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_ld1) begin
                r_prev_err <= w_err;
                r_integ    <= w_integ;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && w_rdy0) begin
            r_meas <= s_axis_tdata[VALUE_W-1:0];
            r_setp <= s_axis_tdata[2*VALUE_W-1:VALUE_W];
        end
        if (w_ld1) begin
            r_err       <= w_err;
            r_diff      <= w_diff;
            r_integ_val <= w_integ;
        end
        if (r_v1 && w_rdy2) begin
            r_p_prod <= PROD_W'(w_cfg.prop_gain)  * PROD_W'(r_err);
            r_i_prod <= PROD_W'(w_cfg.integ_gain) * PROD_W'(r_integ_val);
            r_d_prod <= PROD_W'(w_cfg.deriv_gain) * PROD_W'(r_diff);
        end
        if (r_v2 && w_rdy3) begin
            r_drive <= w_drive;
        end
    end

    // stored error never leaves the error limits
    a_prev_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prev_err >= ERROR_MIN) && (r_prev_err <= ERROR_MAX))
        else $error("previous error outside error limits");

    // controller state moves only when a request enters the error stage
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_ld1 |=> $stable(r_prev_err) && $stable(r_integ))
        else $error("controller state changed without a request");

    // difference in flight stays within its limits
    a_diff_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (r_diff >= DIFF_MIN) && (r_diff <= DIFF_MAX))
        else $error("difference outside its limits");

    // offered drive respects ordered drive limits
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && (w_cfg.drive_low <= w_cfg.drive_high)) |->
        (r_drive >= w_cfg.drive_low) && (r_drive <= w_cfg.drive_high))
        else $error("drive outside drive limits");

endmodule

`default_nettype wire

>>> dv/cpid_drive_checker.sv
// checker for the clamped pid controller: follows the config port and both streams,
// works out the expected drive per request and compares it with each result
// depends on cpid_pkg for the register indexes, the settings struct and its reset
`timescale 1ns / 1ps

module cpid_drive_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [cpid_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [cpid_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                 i_s_tvalid,
    input  wire logic                                 i_s_tready,
    input  wire logic [2*cpid_pkg::VALUE_W-1:0]       i_s_tdata,   // measured, setpoint
    input  wire logic                                 i_m_tvalid,
    input  wire logic                                 i_m_tready,
    input  wire logic [cpid_pkg::VALUE_W-1:0]         i_m_tdata,   // drive
    output int                                        o_fail_count,
    output int                                        o_outstanding
);
    import cpid_pkg::*;

    localparam longint ERR_FLOOR  = -256;
    localparam longint ERR_CEIL   = 256;
    localparam longint DIFF_FLOOR = -256;
    localparam longint DIFF_CEIL  = 256;
    localparam int     MAX_REPORTS = 10;

    t_cpid_cfg                 settings;
    logic signed [VALUE_W-1:0] last_error;
    logic signed [VALUE_W-1:0] integ_acc;
    logic signed [VALUE_W-1:0] expected_drive[$];
    int                        result_count;

    // lower bound first, so an inverted pair ends on the upper bound
    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        longint r;
        r = v;
        if (r < lo) begin
            r = lo;
        end
        if (r > hi) begin
            r = hi;
        end
        return r;
    endfunction

    // one control tick: returns the drive and advances the error history and the integral
    function automatic logic signed [VALUE_W-1:0] pid_drive(
        input logic signed [VALUE_W-1:0] meas,
        input logic signed [VALUE_W-1:0] setp
    );
        longint err;
        longint diff;
        longint integ;
        longint total;
        err   = clamp_to(longint'(setp) - longint'(meas), ERR_FLOOR, ERR_CEIL);
        diff  = clamp_to(err - longint'(last_error), DIFF_FLOOR, DIFF_CEIL);
        integ = clamp_to(longint'(integ_acc) + err,
                         longint'($signed(settings.integral_low)),
                         longint'($signed(settings.integral_high)));
        total = longint'($signed(settings.prop_gain)) * err
              + longint'($signed(settings.integ_gain)) * integ
              + longint'($signed(settings.deriv_gain)) * diff;
        total = clamp_to(total, longint'($signed(settings.drive_low)),
                         longint'($signed(settings.drive_high)));
        last_error = err[VALUE_W-1:0];
        integ_acc  = integ[VALUE_W-1:0];
        return total[VALUE_W-1:0];
    endfunction

    // everything is sampled on the rising edge, before the block's outputs move
    always @(posedge i_clk) begin : track_requests
        logic signed [VALUE_W-1:0] want;
        if (!i_rst_n) begin
            settings      = CFG_RESET;
            last_error    = '0;
            integ_acc     = '0;
            result_count  = 0;
            o_fail_count  = 0;
            expected_drive.delete();
        end else begin
            // register writes; unknown indexes leave the settings alone
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PROP_GAIN:     settings.prop_gain     = i_cfg_data;
                    REG_INTEG_GAIN:    settings.integ_gain    = i_cfg_data;
                    REG_DERIV_GAIN:    settings.deriv_gain    = i_cfg_data;
                    REG_INTEGRAL_LOW:  settings.integral_low  = i_cfg_data;
                    REG_INTEGRAL_HIGH: settings.integral_high = i_cfg_data;
                    REG_DRIVE_LOW:     settings.drive_low     = i_cfg_data;
                    REG_DRIVE_HIGH:    settings.drive_high    = i_cfg_data;
                    default: ;
                endcase
            end
            // result side: compare with the oldest expected drive
            if (i_m_tvalid && i_m_tready) begin
                if (expected_drive.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= MAX_REPORTS) begin
                        $display("result %0d: drive %0d arrived with no request pending",
                                 result_count, $signed(i_m_tdata));
                    end
                end else begin
                    want = expected_drive.pop_front();
                    if (i_m_tdata !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= MAX_REPORTS) begin
                            $display("result %0d: drive expected %0d, got %0d",
                                     result_count, want, $signed(i_m_tdata));
                        end
                    end
                end
                result_count++;
            end
            // request side: predict the drive for each accepted request
            if (i_s_tvalid && i_s_tready) begin
                expected_drive.push_back(pid_drive(i_s_tdata[VALUE_W-1:0],
                                                   i_s_tdata[2*VALUE_W-1:VALUE_W]));
            end
        end
        o_outstanding = expected_drive.size();
    end

endmodule

>>> dv/clamped_pid_controller_test.sv
// top of the clamped pid controller testbench: clock, reset, config writes and request
// stimulus with random idling on both streams; verdict from cpid_drive_checker
// depends on cpid_pkg, cpid_drive_checker and clamped_pid_controller
`timescale 1ns / 1ps

module clamped_pid_controller_test;
    import cpid_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int IDLE_PERCENT   = 10;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_REQUESTS = 117;
    localparam int LIMIT_CYCLES   = 200000;
    localparam logic [CFG_INDEX_W-1:0] REG_INDEX_SPARE = 3'd7;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [2*VALUE_W-1:0]     s_axis_tdata = '0;   // measured, setpoint
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [VALUE_W-1:0]       m_axis_tdata;        // drive

    int  fail_count;
    int  outstanding;
    int  cycle_count = 0;
    bit  steady_run = 1'b0;
    bit  hold_off_armed = 1'b0;

    clamped_pid_controller i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    cpid_drive_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // 12 ns clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("clamped_pid_controller regression: fail");
        $finish;
    end

    // result sink: random back-pressure, one long hold-off when armed
    initial begin : result_sink
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_off_armed && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else if (!steady_run && $urandom_range(0, 99) < IDLE_PERCENT) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // raise a register write for the next edge; the caller lowers the enable
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    task automatic write_settings(input t_cpid_cfg cfg, input bit add_spare_write);
        write_reg(REG_PROP_GAIN, cfg.prop_gain);
        write_reg(REG_INTEG_GAIN, cfg.integ_gain);
        write_reg(REG_DERIV_GAIN, cfg.deriv_gain);
        write_reg(REG_INTEGRAL_LOW, cfg.integral_low);
        write_reg(REG_INTEGRAL_HIGH, cfg.integral_high);
        write_reg(REG_DRIVE_LOW, cfg.drive_low);
        write_reg(REG_DRIVE_HIGH, cfg.drive_high);
        // a write to an unused index must change nothing
        if (add_spare_write) begin
            write_reg(REG_INDEX_SPARE, 16'($urandom));
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // offer one request, with random idle cycles ahead of it, and wait for acceptance
    task automatic send_request(input logic [15:0] meas, input logic [15:0] setp);
        while (!steady_run && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {setp, meas};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
    endtask

    // sampled away from the rising edge so the checker has settled
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] extreme_word();
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            default: return 16'hffff;
        endcase
    endfunction

    function automatic logic [15:0] gain_word();
        case ($urandom_range(0, 7))
            0, 1:       return extreme_word();
            2, 3, 4, 5: return 16'(int'($urandom_range(0, 128)) - 64);
            default:    return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] limit_word();
        case ($urandom_range(0, 7))
            0, 1:       return extreme_word();
            2, 3, 4, 5: return 16'(int'($urandom_range(0, 8000)) - 4000);
            default:    return 16'($urandom);
        endcase
    endfunction

    // limit pairs are mostly ordered, sometimes left inverted
    function automatic t_cpid_cfg random_settings();
        t_cpid_cfg cfg;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        logic signed [15:0] t;
        cfg.prop_gain  = gain_word();
        cfg.integ_gain = gain_word();
        cfg.deriv_gain = gain_word();
        lo = limit_word();
        hi = limit_word();
        if (lo > hi && $urandom_range(0, 4) != 0) begin
            t = lo;
            lo = hi;
            hi = t;
        end
        cfg.integral_low  = lo;
        cfg.integral_high = hi;
        lo = limit_word();
        hi = limit_word();
        if (lo > hi && $urandom_range(0, 4) != 0) begin
            t = lo;
            lo = hi;
            hi = t;
        end
        cfg.drive_low  = lo;
        cfg.drive_high = hi;
        return cfg;
    endfunction

    // mostly a setpoint close to the measurement so the clamps open up, plus noise
    task automatic random_request();
        int kind;
        int m;
        int s;
        logic [15:0] w;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            w = 16'($urandom);
            m = int'($signed(w));
            s = m + int'($urandom_range(0, 600)) - 300;
            if (s > 32767) begin
                s = 32767;
            end
            if (s < -32768) begin
                s = -32768;
            end
            send_request(w, 16'(s));
        end else if (kind < 85) begin
            send_request(16'($urandom), 16'($urandom));
        end else begin
            send_request(extreme_word(), extreme_word());
        end
    endtask

    // main sequence
    initial begin : stimulus
        t_cpid_cfg cfg;
        int phase;
        int n;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: error clamps both ways, difference clamp, integral windup
        send_request(16'd0, 16'd0);
        send_request(16'h8000, 16'h7fff);
        send_request(16'h7fff, 16'h8000);
        send_request(16'd0, 16'd200);
        send_request(16'd0, 16'd200);
        send_request(16'd0, 16'd200);
        send_request(16'd0, 16'hffff);
        send_request(16'h8000, 16'h8000);
        send_request(16'h7fff, 16'h7fff);
        wait_drained();

        // largest gains and widest limits: sums far beyond 16 bits
        cfg = CFG_RESET;
        cfg.prop_gain     = 16'sh7fff;
        cfg.integ_gain    = 16'sh7fff;
        cfg.deriv_gain    = 16'sh7fff;
        cfg.integral_low  = 16'sh8000;
        cfg.integral_high = 16'sh7fff;
        cfg.drive_low     = 16'sh8000;
        cfg.drive_high    = 16'sh7fff;
        write_settings(cfg, 1'b1);
        send_request(16'h8000, 16'h7fff);
        send_request(16'h8000, 16'h7fff);
        send_request(16'h8000, 16'h7fff);
        send_request(16'h7fff, 16'h8000);
        send_request(16'h7fff, 16'h8000);
        wait_drained();

        // most negative gains, both limit pairs inverted
        cfg.prop_gain     = 16'sh8000;
        cfg.integ_gain    = 16'sh8000;
        cfg.deriv_gain    = 16'sh8000;
        cfg.integral_low  = 16'sd100;
        cfg.integral_high = -16'sd100;
        cfg.drive_low     = 16'sd1000;
        cfg.drive_high    = -16'sd1000;
        write_settings(cfg, 1'b0);
        send_request(16'd0, 16'd50);
        send_request(16'd0, 16'hffce);
        send_request(16'h8000, 16'h7fff);
        send_request(16'd0, 16'd0);
        wait_drained();

        // unit gains, inverted integral limits only
        cfg.prop_gain     = 16'sd1;
        cfg.integ_gain    = 16'sd1;
        cfg.deriv_gain    = 16'sd1;
        cfg.integral_low  = 16'sd50;
        cfg.integral_high = -16'sd50;
        cfg.drive_low     = 16'sh8000;
        cfg.drive_high    = 16'sh7fff;
        write_settings(cfg, 1'b0);
        send_request(16'd0, 16'd10);
        send_request(16'd0, 16'hfed4);
        send_request(16'd5, 16'd5);
        wait_drained();

        // random phases, each with fresh settings
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_settings(random_settings(), $urandom_range(0, 3) == 0);
            steady_run     <= (phase == 3);
            hold_off_armed <= (phase == 1);
            for (n = 0; n < PHASE_REQUESTS; n++) begin
                random_request();
            end
            wait_drained();
        end

        if (fail_count == 0 && outstanding == 0) begin
            $display("clamped_pid_controller regression: pass");
        end else begin
            $display("clamped_pid_controller regression: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/cpid_pkg.sv
rtl/core/cpid_regs.sv
rtl/core/clamped_pid_controller.sv
dv/cpid_drive_checker.sv
dv/clamped_pid_controller_test.sv
